// File: hdl/utmc_pkg.sv
// Shared types and codes for the uniform tile map compressor.
// Command codes, result select codes and the controller/datapath handshake structs.
// No dependencies.
package utmc_pkg;

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMPRESS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET      = 2'd2;

  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] SIDE_LOG2_RESET = 4'd8;

  localparam logic [7:0] PIXEL_NOT_READY = 8'hFF;

  typedef logic [2:0] res_sel_t;
  localparam res_sel_t RES_HOLD = 3'd0;
  localparam res_sel_t RES_ZERO = 3'd1;
  localparam res_sel_t RES_FF   = 3'd2;
  localparam res_sel_t RES_TBL  = 3'd3;
  localparam res_sel_t RES_MIX  = 3'd4;

  typedef struct packed {
    logic     walk_start;
    logic     walk_step;
    logic     walk_done;
    logic     get_start;
    logic     load_wr;
    res_sel_t res_sel;
  } utmc_cmd_t;

  typedef struct packed {
    logic map_ready;
    logic walk_last;
    logic tbl_uniform;
  } utmc_sts_t;

endpackage

// File: hdl/uniform_tile_map_compressor_unit.sv
// Top level of the uniform tile map compressor.
// Joins the controller (utmc_ctrl) and the datapath (utmc_dpath); uses utmc_pkg.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ----------------------------
//  input     in_command in_x in_y in_value           word taken when start & !busy
//  result    out_pixel out_uniform_block             word valid for the one cycle
//            out_real_blocks out_map_ready           that out_strobe is high
//  config    cfg_we cfg_data (map side log2)         written at any edge with cfg_we
//
// Cycles: load (and the unused command) keeps busy low, so a word can enter every
// cycle; its result strobes the next cycle. Get before any compress answers the next
// cycle; after a compress it goes through a table read and, for a mixed block, a
// mixed store read before it answers. Compress walks the whole map: the walk reads
// one source byte per cycle through the single read port of the source RAM.
// Reset is synchronous and active low; it clears control state, the map-ready flag,
// the block count and sets the map side log2 to 8. The RAMs are not cleared.
// The receiver cannot stall: each result word is shown for one cycle only.
module uniform_tile_map_compressor_unit #(
  parameter int MAX_SIDE   = 256,
  parameter int BLOCK_SIDE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [utmc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [utmc_pkg::CMD_W-1:0]      in_command,
  input  logic [7:0]                      in_x,
  input  logic [7:0]                      in_y,
  input  logic [7:0]                      in_value,
  output logic                            out_strobe,
  output logic [7:0]                      out_pixel,
  output logic                            out_uniform_block,
  output logic [10:0]                     out_real_blocks,
  output logic                            out_map_ready
);
  import utmc_pkg::*;

  // command and status between controller and datapath
  utmc_cmd_t cmd;
  utmc_sts_t sts;

  // sequence each word: hold busy high through compress walks and get lookups
  utmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // storage, walk counters, block compare and result registers
  utmc_dpath #(
    .MAX_SIDE   (MAX_SIDE),
    .BLOCK_SIDE (BLOCK_SIDE)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_x              (in_x),
    .in_y              (in_y),
    .in_value          (in_value),
    .cmd               (cmd),
    .sts               (sts),
    .out_pixel         (out_pixel),
    .out_uniform_block (out_uniform_block),
    .out_real_blocks   (out_real_blocks),
    .out_map_ready     (out_map_ready)
  );

endmodule

// File: hdl/utmc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module utmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/utmc_ctrl.sv
// Controller state machine of the tile map compressor.
// Sequences load, compress walk and get lookups; drives the result strobe.
// Depends on utmc_pkg.
module utmc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [utmc_pkg::CMD_W-1:0]      in_command,
  input  utmc_pkg::utmc_sts_t             sts,
  output utmc_pkg::utmc_cmd_t             cmd,
  output logic                            busy,
  output logic                            out_strobe
);
  import utmc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_GTBL  = 3'd3;
  localparam logic [2:0] ST_GPIX  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    cmd.res_sel = RES_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_COMPRESS: begin
              cmd.walk_start = 1'b1;
              state_nxt      = ST_WALK;
            end
            CMD_GET: begin
              if (sts.map_ready) begin
                cmd.get_start = 1'b1;
                state_nxt     = ST_GTBL;
              end else begin
                cmd.res_sel = RES_FF;
                strobe_nxt  = 1'b1;
              end
            end
            default: begin
              cmd.load_wr = (in_command == CMD_LOAD);
              cmd.res_sel = RES_ZERO;
              strobe_nxt  = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.walk_done = 1'b1;
        cmd.res_sel   = RES_ZERO;
        strobe_nxt    = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_GTBL: begin
        if (sts.tbl_uniform) begin
          cmd.res_sel = RES_TBL;
          strobe_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_GPIX;
        end
      end
      ST_GPIX: begin
        cmd.res_sel = RES_MIX;
        strobe_nxt  = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;

  a_strobe_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (state_r == ST_IDLE))
    else $error("result strobe while a command is in flight");

  a_compress_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_COMPRESS) |=> busy)
    else $error("compress accepted but walk did not start");

  a_gpix_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GPIX) |=> strobe_r)
    else $error("mixed block lookup gave no result");

  a_drain_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> $past(state_r) == ST_WALK)
    else $error("drain entered without a walk");

endmodule

// File: hdl/utmc_dpath.sv
// Datapath of the tile map compressor: source map, block table and mixed block store,
// the block walk counters and compare logic, and the result registers.
// Depends on utmc_pkg and utmc_ram.
module utmc_dpath #(
  parameter int MAX_SIDE   = 256,
  parameter int BLOCK_SIDE = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [utmc_pkg::CFG_W-1:0]  cfg_data,
  input  logic [7:0]                  in_x,
  input  logic [7:0]                  in_y,
  input  logic [7:0]                  in_value,
  input  utmc_pkg::utmc_cmd_t         cmd,
  output utmc_pkg::utmc_sts_t         sts,
  output logic [7:0]                  out_pixel,
  output logic                        out_uniform_block,
  output logic [10:0]                 out_real_blocks,
  output logic                        out_map_ready
);
  import utmc_pkg::*;

  localparam int SIDE_CAP  = (MAX_SIDE > BLOCK_SIDE) ? MAX_SIDE : BLOCK_SIDE;
  localparam int CW        = $clog2(SIDE_CAP);
  localparam int BS        = $clog2(BLOCK_SIDE);
  localparam int TBL       = CW - BS;
  localparam int TBW       = (TBL > 0) ? TBL : 1;
  localparam int TW        = (2 * TBL > 0) ? 2 * TBL : 1;
  localparam int AW        = 2 * CW;
  localparam int OW        = 2 * BS;
  localparam int DW        = (TW > 8) ? TW : 8;
  localparam int WW        = DW + 1;
  localparam int CNTW      = 2 * TBL + 1;
  localparam int SRC_DEPTH = SIDE_CAP * SIDE_CAP;
  localparam int TBL_DEPTH = 1 << (2 * TBL);
  localparam logic [TBW-1:0] BLK_FULL = TBW'((1 << TBL) - 1);

  logic [CFG_W-1:0] cfg_r;
  logic [CFG_W-1:0] sl_now, sl_lat_r, shift_amt;
  logic             valid_r;
  logic [CNTW-1:0]  count_r;
  logic [BS-1:0]    kx_r, ky_r;
  logic [TBW-1:0]   bx_r, by_r;
  logic             rd_v_r;
  logic [OW-1:0]    offs_d_r;
  logic [TW-1:0]    tba_d_r;
  logic [7:0]       first_r;
  logic             same_r;
  logic [OW-1:0]    get_off_r;
  logic [7:0]       pixel_r;
  logic             uni_r;

  logic [CW-1:0]    coord_mask;
  logic [TBW-1:0]   blk_mask;
  logic             ld_ok;
  logic [AW-1:0]    ld_addr;
  logic [CW-1:0]    wx, wy;
  logic [AW-1:0]    src_raddr;
  logic [TW-1:0]    walk_tba;
  logic [7:0]       src_rdata;
  logic             kfirst, klast, same_fin;
  logic [AW-1:0]    mix_waddr, mix_raddr;
  logic [7:0]       mix_rdata;
  logic             tbl_we;
  logic [WW-1:0]    tbl_wdata, tbl_rdata;
  logic [CW-1:0]    gxm, gym;
  logic [TBW-1:0]   gxb, gyb;
  logic [BS-1:0]    gxo, gyo;
  logic [TW-1:0]    tbl_raddr;

  // clamp the configured side between one block and the store capacity
  always_comb begin
    if (cfg_r > CFG_W'(CW)) begin
      sl_now = CFG_W'(CW);
    end else if (cfg_r < CFG_W'(BS)) begin
      sl_now = CFG_W'(BS);
    end else begin
      sl_now = cfg_r;
    end
  end

  assign shift_amt  = CFG_W'(CW) - sl_lat_r;
  assign coord_mask = {CW{1'b1}} >> shift_amt;
  assign blk_mask   = BLK_FULL >> shift_amt;

  // load: drop bytes outside the current map
  assign ld_ok   = cmd.load_wr && ((in_x >> sl_now) == 8'd0) && ((in_y >> sl_now) == 8'd0);
  assign ld_addr = (AW'(CW'(in_y)) << CW) | AW'(CW'(in_x));

  // walk address generation
  assign wx        = (CW'(bx_r) << BS) | CW'(kx_r);
  assign wy        = (CW'(by_r) << BS) | CW'(ky_r);
  assign src_raddr = (AW'(wy) << CW) | AW'(wx);
  assign walk_tba  = (TW'(by_r) << TBL) | TW'(bx_r);

  assign sts.walk_last = (&kx_r) && (&ky_r) && (bx_r == blk_mask) && (by_r == blk_mask);

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      kx_r <= '0;
      ky_r <= '0;
      bx_r <= '0;
      by_r <= '0;
    end else if (cmd.walk_step) begin
      kx_r <= kx_r + BS'(1);
      if (&kx_r) begin
        ky_r <= ky_r + BS'(1);
        if (&ky_r) begin
          if (bx_r == blk_mask) begin
            bx_r <= '0;
            by_r <= by_r + TBW'(1);
          end else begin
            bx_r <= bx_r + TBW'(1);
          end
        end
      end
    end
    offs_d_r <= {ky_r, kx_r};
    tba_d_r  <= walk_tba;
  end

  // compare stage: source data arrives in the cycle after its address
  assign kfirst   = (offs_d_r == '0);
  assign klast    = &offs_d_r;
  assign same_fin = same_r && (src_rdata == first_r);

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      if (kfirst) begin
        first_r <= src_rdata;
        same_r  <= 1'b1;
      end else begin
        same_r  <= same_fin;
      end
    end
  end

  // every block is copied into the next free slot; only a mixed block claims it
  assign mix_waddr = (AW'(count_r) << OW) | AW'(offs_d_r);
  assign tbl_we    = rd_v_r && klast;
  assign tbl_wdata = same_fin ? {1'b1, DW'(first_r)} : {1'b0, DW'(count_r[TW-1:0])};

  // get lookup
  assign gxm       = CW'(in_x) & coord_mask;
  assign gym       = CW'(in_y) & coord_mask;
  assign gxb       = TBW'(gxm >> BS);
  assign gyb       = TBW'(gym >> BS);
  assign gxo       = BS'(gxm);
  assign gyo       = BS'(gym);
  assign tbl_raddr = (TW'(gyb) << TBL) | TW'(gxb);
  assign mix_raddr = (AW'(tbl_rdata[TW-1:0]) << OW) | AW'(get_off_r);

  assign sts.tbl_uniform = tbl_rdata[DW];
  assign sts.map_ready   = valid_r;

  always_ff @(posedge clk) begin
    if (cmd.get_start) begin
      get_off_r <= {gyo, gxo};
    end
    if (cmd.walk_start) begin
      sl_lat_r <= sl_now;
    end
    case (cmd.res_sel)
      RES_ZERO: begin
        pixel_r <= 8'd0;
        uni_r   <= 1'b0;
      end
      RES_FF: begin
        pixel_r <= PIXEL_NOT_READY;
        uni_r   <= 1'b0;
      end
      RES_TBL: begin
        pixel_r <= tbl_rdata[7:0];
        uni_r   <= 1'b1;
      end
      RES_MIX: begin
        pixel_r <= mix_rdata;
        uni_r   <= 1'b0;
      end
      default: begin
        pixel_r <= pixel_r;
        uni_r   <= uni_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= SIDE_LOG2_RESET;
      valid_r <= 1'b0;
      count_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.walk_done) begin
        valid_r <= 1'b1;
      end
      if (cmd.walk_start) begin
        count_r <= '0;
      end else if (tbl_we && !same_fin) begin
        count_r <= count_r + CNTW'(1);
      end
      rd_v_r <= cmd.walk_step;
    end
  end

  utmc_ram #(.WIDTH(8), .DEPTH(SRC_DEPTH)) u_src_ram (
    .clk   (clk),
    .we    (ld_ok),
    .waddr (ld_addr),
    .wdata (in_value),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  utmc_ram #(.WIDTH(WW), .DEPTH(TBL_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tba_d_r),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  utmc_ram #(.WIDTH(8), .DEPTH(SRC_DEPTH)) u_mix_ram (
    .clk   (clk),
    .we    (rd_v_r),
    .waddr (mix_waddr),
    .wdata (src_rdata),
    .raddr (mix_raddr),
    .rdata (mix_rdata)
  );

  assign out_pixel         = pixel_r;
  assign out_uniform_block = uni_r;
  assign out_real_blocks   = 11'(count_r);
  assign out_map_ready     = valid_r;

endmodule

// File: dv/uniform_tile_map_compressor_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for uniform_tile_map_compressor_unit: directed script, fill of a
// 32x32 map, then random phases, each result word checked against a typed-in or predicted answer.
// Depends on utmc_pkg and the unit's RTL.
module uniform_tile_map_compressor_unit_tb;
  import utmc_pkg::*;

  // Command 3 has no name in the package; the unit answers it as a load that writes nothing.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAP_CAP = 256;
  localparam int BLK = 8;
  localparam int BLK_LOG2 = 3;
  localparam int TILE_CAP = (MAP_CAP / BLK) * (MAP_CAP / BLK);
  localparam logic [15:0] UNIFORM_TAG = 16'h8000;
  localparam int SIDE_LOG2_LO = 3;
  localparam int SIDE_LOG2_HI = 8;
  // Largest map that gets fully loaded; compress never runs on a larger side.
  localparam int FILL_LOG2 = 5;
  localparam int FILL_BPR = (1 << FILL_LOG2) / BLK;
  localparam int FILL_BLOCKS = FILL_BPR * FILL_BPR;

  typedef struct packed {
    logic [7:0]  pixel;
    logic        uniform_block;
    logic [10:0] real_blocks;
    logic        map_ready;
  } answer_t;

  // Directed script rows: one word, one 8x8 block of loads, or a side register write.
  typedef enum logic [1:0] {ROW_WORD, ROW_BLOCK, ROW_SIDE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CMD_W-1:0] command;
    logic [7:0]       x;
    logic [7:0]       y;
    logic [7:0]       value;
    logic [7:0]       odd_value;
    logic             typed;
    answer_t          ans;
  } script_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             start = 1'b0;
  logic             busy;
  logic [CMD_W-1:0] in_command = CMD_LOAD;
  logic [7:0]       in_x = '0;
  logic [7:0]       in_y = '0;
  logic [7:0]       in_value = '0;
  logic             out_strobe;
  logic [7:0]       out_pixel;
  logic             out_uniform_block;
  logic [10:0]      out_real_blocks;
  logic             out_map_ready;

  // Predictor state: source map, block table, mixed block store and the latched side.
  logic [7:0]       src_img [0:MAP_CAP*MAP_CAP-1];
  logic [15:0]      tile_tbl [0:TILE_CAP-1];
  logic [7:0]       mixed_img [0:MAP_CAP*MAP_CAP-1];
  int               mixed_total;
  logic             map_built;
  logic [CFG_W-1:0] side_cfg;
  int               built_log2;

  // Per-block fill record of the fill pass, so odd bytes can be repaired later.
  logic [7:0]       blk_base [0:FILL_BLOCKS-1];
  logic [2:0]       odd_px [0:FILL_BLOCKS-1];
  logic [2:0]       odd_py [0:FILL_BLOCKS-1];

  answer_t          pending_answers [$];
  answer_t          want_ans;
  int               err_count = 0;
  int               idle_pct = 17;
  script_row_t      script [$];

  uniform_tile_map_compressor_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_x              (in_x),
    .in_y              (in_y),
    .in_value          (in_value),
    .out_strobe        (out_strobe),
    .out_pixel         (out_pixel),
    .out_uniform_block (out_uniform_block),
    .out_real_blocks   (out_real_blocks),
    .out_map_ready     (out_map_ready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Clamp the register to the sides the unit supports: one block up to the full map.
  function automatic int side_log2(logic [CFG_W-1:0] c);
    int s;
    s = c;
    if (s > SIDE_LOG2_HI) s = SIDE_LOG2_HI;
    if (s < SIDE_LOG2_LO) s = SIDE_LOG2_LO;
    return s;
  endfunction

  // Walk the blocks in raster order; uniform blocks get a tagged table entry, mixed ones
  // the next store index and a copy of their 64 bytes.
  task automatic build_tile_map();
    int         sl, bpr, x0, y0, cnt;
    logic [7:0] lead;
    logic       flat;
    sl = side_log2(side_cfg);
    bpr = 1 << (sl - BLK_LOG2);
    cnt = 0;
    for (int i = 0; i < bpr * bpr; i++) begin
      x0 = (i % bpr) * BLK;
      y0 = (i / bpr) * BLK;
      lead = src_img[y0 * MAP_CAP + x0];
      flat = 1'b1;
      for (int k = 0; k < BLK * BLK; k++)
        if (src_img[(y0 + k / BLK) * MAP_CAP + x0 + k % BLK] != lead) flat = 1'b0;
      if (flat) begin
        tile_tbl[i] = UNIFORM_TAG | {8'h00, lead};
      end else begin
        tile_tbl[i] = 16'(cnt) & ~UNIFORM_TAG;
        for (int k = 0; k < BLK * BLK; k++)
          mixed_img[cnt * BLK * BLK + k] = src_img[(y0 + k / BLK) * MAP_CAP + x0 + k % BLK];
        cnt++;
      end
    end
    mixed_total = cnt;
    built_log2 = sl;
    map_built = 1'b1;
  endtask

  // Decode one pixel with the side latched at the last compress; returns {uniform, pixel}.
  function automatic logic [8:0] decode_pixel(logic [7:0] x, logic [7:0] y);
    int          msk, xm, ym, ti, addr;
    logic [15:0] entry;
    msk = (1 << built_log2) - 1;
    xm = x & msk;
    ym = y & msk;
    ti = ((ym >> BLK_LOG2) << (built_log2 - BLK_LOG2)) + (xm >> BLK_LOG2);
    entry = tile_tbl[ti];
    if (entry[15]) return {1'b1, entry[7:0]};
    addr = (int'(entry[14:0]) << (2 * BLK_LOG2)) + ((ym % BLK) << BLK_LOG2) + (xm % BLK);
    return {1'b0, mixed_img[addr]};
  endfunction

  // Advance the predictor by one accepted word and work out its result word.
  task automatic predict_answer(input logic [CMD_W-1:0] cmd, input logic [7:0] x,
                                input logic [7:0] y, input logic [7:0] v,
                                output answer_t a);
    int         side;
    logic [8:0] hit;
    a = '0;
    case (cmd)
      CMD_LOAD: begin
        side = 1 << side_log2(side_cfg);
        if (x < side && y < side) src_img[y * MAP_CAP + x] = v;
      end
      CMD_COMPRESS: build_tile_map();
      CMD_GET: begin
        if (map_built) begin
          hit = decode_pixel(x, y);
          a.pixel = hit[7:0];
          a.uniform_block = hit[8];
        end else begin
          a.pixel = PIXEL_NOT_READY;
        end
      end
      default: ;
    endcase
    a.real_blocks = 11'(mixed_total);
    a.map_ready = map_built;
  endtask

  // Offer one word, optionally after a random idle gap, and hold it until busy is low at
  // an edge. The expectation is queued at the accepting edge.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [7:0] x,
                           input logic [7:0] y, input logic [7:0] v,
                           input logic typed, input answer_t typed_ans);
    answer_t a;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_x <= x;
    in_y <= y;
    in_value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_answer(cmd, x, y, v, a);
    pending_answers.push_back(typed ? typed_ans : a);
  endtask

  // Drop start and hold off until every expected result word has come back.
  task automatic drain_answers();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the side register only while the unit is idle.
  task automatic write_side(input logic [CFG_W-1:0] v);
    drain_answers();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    side_cfg = v;
  endtask

  // Load one 8x8 block in raster order: all base bytes with one odd byte, or pure noise.
  task automatic load_block(input int bx, input int by, input logic [7:0] base,
                            input int ox, input int oy, input logic [7:0] odd_v,
                            input logic noise);
    for (int k = 0; k < BLK * BLK; k++) begin
      int px, py;
      px = k % BLK;
      py = k / BLK;
      send_word(CMD_LOAD, 8'(bx * BLK + px), 8'(by * BLK + py),
                noise ? 8'($urandom) : (px == ox && py == oy) ? odd_v : base, 1'b0, '0);
    end
  endtask

  // Read back the map at random points; mix in a few stray commands of any kind.
  task automatic probe_map(input int n);
    repeat (n) begin
      if ($urandom_range(7) == 0)
        send_word(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      else
        send_word(CMD_GET, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    end
  endtask

  function automatic answer_t reply(logic [7:0] p, logic u, logic [10:0] rb, logic rdy);
    answer_t a;
    a.pixel = p;
    a.uniform_block = u;
    a.real_blocks = rb;
    a.map_ready = rdy;
    return a;
  endfunction

  function automatic script_row_t mk_row(row_kind_t k, logic [CMD_W-1:0] c,
                                         logic [7:0] x, logic [7:0] y, logic [7:0] v,
                                         logic [7:0] ov, logic typed, answer_t a);
    script_row_t r;
    r.kind = k;
    r.command = c;
    r.x = x;
    r.y = y;
    r.value = v;
    r.odd_value = ov;
    r.typed = typed;
    r.ans = a;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result side: every strobed word is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_answers.size() == 0) begin
        err_count++;
        $display("%0t: result word with nothing expected: pixel %0d uniform %0b blocks %0d",
                 $time, out_pixel, out_uniform_block, out_real_blocks);
      end else begin
        want_ans = pending_answers.pop_front();
        check_field("pixel", 11'(want_ans.pixel), 11'(out_pixel));
        check_field("uniform_block", 11'(want_ans.uniform_block), 11'(out_uniform_block));
        check_field("real_blocks", want_ans.real_blocks, out_real_blocks);
        check_field("map_ready", 11'(want_ans.map_ready), 11'(out_map_ready));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int s, bx, by, r, px, py;

    // Predictor reset state matches the unit's: no map yet, full-size side.
    mixed_total = 0;
    map_built = 1'b0;
    side_cfg = SIDE_LOG2_RESET;
    built_log2 = side_log2(SIDE_LOG2_RESET);

    // Directed script. Answers are typed in where they are plain; the rest go through
    // the predictor.
    // Before any compress: get answers 0xFF at any point, the unused command answers zeros.
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
                            reply(8'hFF, 1'b0, 11'd0, 1'b0)));
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1,
                            reply(8'hFF, 1'b0, 11'd0, 1'b0)));
    script.push_back(mk_row(ROW_WORD, CMD_UNUSED, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1,
                            reply(8'h00, 1'b0, 11'd0, 1'b0)));
    // Below-range side clamps to a single 8x8 block; loads past its edge are dropped.
    script.push_back(mk_row(ROW_SIDE, CMD_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0));
    script.push_back(mk_row(ROW_WORD, CMD_LOAD, 8'd8, 8'd0, 8'h55, 8'd0, 1'b1,
                            reply(8'h00, 1'b0, 11'd0, 1'b0)));
    script.push_back(mk_row(ROW_WORD, CMD_LOAD, 8'd0, 8'd8, 8'hAA, 8'd0, 1'b1,
                            reply(8'h00, 1'b0, 11'd0, 1'b0)));
    // One uniform block of 0xFF, compressed; gets wrap onto it.
    script.push_back(mk_row(ROW_BLOCK, CMD_LOAD, 8'd0, 8'd0, 8'hFF, 8'hFF, 1'b0, '0));
    script.push_back(mk_row(ROW_WORD, CMD_COMPRESS, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
                            reply(8'h00, 1'b0, 11'd0, 1'b1)));
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
                            reply(8'hFF, 1'b1, 11'd0, 1'b1)));
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1,
                            reply(8'hFF, 1'b1, 11'd0, 1'b1)));
    // Reload as zeros with a single 0xFF in the last byte; the old map stays until compress.
    script.push_back(mk_row(ROW_BLOCK, CMD_LOAD, 8'd7, 8'd7, 8'h00, 8'hFF, 1'b0, '0));
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd3, 8'd4, 8'd0, 8'd0, 1'b1,
                            reply(8'hFF, 1'b1, 11'd0, 1'b1)));
    script.push_back(mk_row(ROW_WORD, CMD_COMPRESS, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
                            reply(8'h00, 1'b0, 11'd1, 1'b1)));
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd7, 8'd7, 8'd0, 8'd0, 1'b1,
                            reply(8'hFF, 1'b0, 11'd1, 1'b1)));
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
                            reply(8'h00, 1'b0, 11'd1, 1'b1)));
    // Move the odd byte to the first position of the block.
    script.push_back(mk_row(ROW_WORD, CMD_LOAD, 8'd0, 8'd0, 8'h01, 8'd0, 1'b1,
                            reply(8'h00, 1'b0, 11'd1, 1'b1)));
    script.push_back(mk_row(ROW_WORD, CMD_LOAD, 8'd7, 8'd7, 8'h00, 8'd0, 1'b1,
                            reply(8'h00, 1'b0, 11'd1, 1'b1)));
    script.push_back(mk_row(ROW_WORD, CMD_COMPRESS, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0));
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0));
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd6, 8'd1, 8'd0, 8'd0, 1'b0, '0));
    // Above-range side clamps to the full map, but gets keep the side latched at compress.
    script.push_back(mk_row(ROW_SIDE, CMD_LOAD, 8'd0, 8'd0, 8'd15, 8'd0, 1'b0, '0));
    script.push_back(mk_row(ROW_WORD, CMD_GET, 8'd15, 8'd15, 8'd0, 8'd0, 1'b0, '0));
    script.push_back(mk_row(ROW_WORD, CMD_LOAD, 8'd255, 8'd255, 8'h80, 8'd0, 1'b0, '0));
    script.push_back(mk_row(ROW_WORD, CMD_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0));

    // Hold reset low, then release it once.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_WORD: send_word(script[i].command, script[i].x, script[i].y, script[i].value,
                            script[i].typed, script[i].ans);
        ROW_BLOCK: load_block(0, 0, script[i].value, script[i].x, script[i].y,
                              script[i].odd_value, 1'b0);
        default: write_side(script[i].value[CFG_W-1:0]);
      endcase
    end

    // Fill the 32x32 map with near-uniform blocks: one odd byte each, so every block
    // is mixed and the count equals the number of blocks.
    write_side(CFG_W'(FILL_LOG2));
    for (int b = 0; b < FILL_BLOCKS; b++) begin
      blk_base[b] = 8'($urandom);
      odd_px[b] = 3'($urandom);
      odd_py[b] = 3'($urandom);
      load_block(b % FILL_BPR, b / FILL_BPR, blk_base[b], odd_px[b],
                 odd_py[b], blk_base[b] ^ 8'($urandom_range(1, 255)), 1'b0);
    end
    send_word(CMD_COMPRESS, 8'd0, 8'd0, 8'd0, 1'b1,
              reply(8'h00, 1'b0, 11'(FILL_BLOCKS), 1'b1));
    probe_map(40);

    // Repair about half the blocks back to uniform, so later compresses see both kinds.
    for (int b = 0; b < FILL_BLOCKS; b++) begin
      if ($urandom_range(1) == 1)
        send_word(CMD_LOAD, 8'((b % FILL_BPR) * BLK + odd_px[b]),
                  8'((b / FILL_BPR) * BLK + odd_py[b]), blk_base[b], 1'b0, '0);
    end

    // Random phases: new side, a few edits of the map, compress, then a burst of reads.
    // Every byte of the 32x32 map is written by now, so any side up to 32 may be compressed.
    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = (ph < 3) ? 17 : (ph < 6) ? 68 : 0;
      write_side(CFG_W'($urandom_range(0, FILL_LOG2)));
      s = 1 << side_log2(side_cfg);
      repeat ($urandom_range(2, 6)) begin
        r = $urandom_range(99);
        bx = $urandom_range(s / BLK - 1);
        by = $urandom_range(s / BLK - 1);
        px = $urandom_range(BLK - 1);
        py = $urandom_range(BLK - 1);
        if (r < 12) begin
          // Rewrite a whole block: noise, or a base with one odd byte that may match it.
          load_block(bx, by, 8'($urandom), px, py, 8'($urandom), $urandom_range(2) == 0);
        end else if (r < 40) begin
          send_word(CMD_LOAD, 8'($urandom_range(s - 1)), 8'($urandom_range(s - 1)),
                    8'($urandom), 1'b0, '0);
        end else if (r < 55) begin
          // Copy the block's first byte elsewhere in it, nudging it toward uniform.
          send_word(CMD_LOAD, 8'(bx * BLK + px), 8'(by * BLK + py),
                    src_img[by * BLK * MAP_CAP + bx * BLK], 1'b0, '0);
        end else if (r < 70) begin
          send_word(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
        end else if (r < 80) begin
          send_word(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
        end else begin
          send_word(CMD_GET, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
        end
      end
      // Now and then let every result come back before the compress.
      if ($urandom_range(3) == 0) drain_answers();
      send_word(CMD_COMPRESS, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      probe_map($urandom_range(10, 30));
    end

    // Stop sending, wait for the tail of results, then report.
    start <= 1'b0;
    for (int n = 0; n < 200000 && pending_answers.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_answers.size() != 0) begin
      err_count += pending_answers.size();
      $display("%0t: %0d result words never arrived", $time, pending_answers.size());
    end
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
